// ----- sv/rotation_matrix_to_quaternion_top_defines.svh -----
// Assertion helpers for the checker file.
`ifndef ROTATION_MATRIX_TO_QUATERNION_TOP_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_TOP_DEFINES_SVH

// Same-cycle implication, masked during reset.
`define RMQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rmq assertion failed");

// Next-cycle implication, masked during reset.
`define RMQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rmq assertion failed");

// Next-cycle implication that also covers the reset itself.
`define RMQ_ASSERT_RST(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("rmq assertion failed");

`endif

// ----- sv/rmq_pkg.sv -----
package rmq_pkg;

    // Quaternion component slots: scalar part first, then the three axes.
    typedef logic [1:0] t_slot;

    localparam t_slot SLOT_W = 2'd0;
    localparam t_slot SLOT_X = 2'd1;
    localparam t_slot SLOT_Y = 2'd2;
    localparam t_slot SLOT_Z = 2'd3;

    // Cyclic successor of an axis; the scalar slot maps to itself.
    function automatic t_slot axis_next(input t_slot a);
        t_slot r;
        unique case (a)
            SLOT_W:  r = SLOT_W;
            SLOT_X:  r = SLOT_Y;
            SLOT_Y:  r = SLOT_Z;
            SLOT_Z:  r = SLOT_X;
            default: r = SLOT_W;
        endcase
        return r;
    endfunction

endpackage

// ----- sv/rmq_mat_if.sv -----
interface rmq_mat_if #(parameter int W = 16);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] m11;
    logic signed [W-1:0] m12;
    logic signed [W-1:0] m13;
    logic signed [W-1:0] m21;
    logic signed [W-1:0] m22;
    logic signed [W-1:0] m23;
    logic signed [W-1:0] m31;
    logic signed [W-1:0] m32;
    logic signed [W-1:0] m33;

    modport source (output valid, m11, m12, m13, m21, m22, m23, m31, m32, m33,
                    input ready);
    modport sink   (input valid, m11, m12, m13, m21, m22, m23, m31, m32, m33,
                    output ready);
endinterface

// ----- sv/rmq_quat_if.sv -----
interface rmq_quat_if #(parameter int W = 16);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] qw;
    logic signed [W-1:0] qx;
    logic signed [W-1:0] qy;
    logic signed [W-1:0] qz;
    logic                degenerate;

    modport source (output valid, qw, qx, qy, qz, degenerate, input ready);
    modport sink   (input valid, qw, qx, qy, qz, degenerate, output ready);
endinterface

// ----- sv/rotation_matrix_to_quaternion_top.sv -----
// Rotation matrix to unit quaternion, signed fixed point with DATA_WIDTH-2
// fraction bits. One matrix is taken per cycle unless the output stalls, and
// results leave in order through one input register, a square-root pipeline
// that resolves one root bit per stage, a setup stage and three lane dividers
// that resolve one quotient bit per stage, and the output register that
// rounds, saturates and steers the components. A stall at the output freezes
// the whole pipeline; input ready is high whenever the output register is
// empty or being taken. A non-positive radicand gives zero components with
// degenerate set.
module rotation_matrix_to_quaternion_top #(
    parameter int DATA_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rmq_mat_if.sink     i_mat,
    rmq_quat_if.source  o_quat
);
    import rmq_pkg::*;

    localparam int W   = DATA_WIDTH;
    localparam int SW1 = 6 + 3 * (W + 1);
    localparam int SW2 = 6 + W;
    localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0]        NLIM = {1'b1, {(W-1){1'b0}}};

    logic en;

    // input register
    logic [W:0]  p_rad;
    logic        p_degen;
    t_slot       p_hs;
    logic        p_neg [3];
    logic [W:0]  p_mag [3];

    logic        r_p_vld;
    logic [W:0]  r_p_rad;
    logic        r_p_degen;
    t_slot       r_p_hs;
    logic        r_p_neg [3];
    logic [W:0]  r_p_mag [3];

    rmq_prep #(.W(W)) u_prep (
        .i_m11   (i_mat.m11),
        .i_m12   (i_mat.m12),
        .i_m13   (i_mat.m13),
        .i_m21   (i_mat.m21),
        .i_m22   (i_mat.m22),
        .i_m23   (i_mat.m23),
        .i_m31   (i_mat.m31),
        .i_m32   (i_mat.m32),
        .i_m33   (i_mat.m33),
        .o_rad   (p_rad),
        .o_degen (p_degen),
        .o_hs    (p_hs),
        .o_neg   (p_neg),
        .o_mag   (p_mag)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else if (en) begin
            r_p_vld <= i_mat.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_rad   <= p_rad;
            r_p_degen <= p_degen;
            r_p_hs    <= p_hs;
            r_p_neg   <= p_neg;
            r_p_mag   <= p_mag;
        end
    end

    // square root
    logic [SW1-1:0] s_side_in;
    logic [SW1-1:0] s_side;
    logic           s_vld;
    logic [W-1:0]   s_root;

    assign s_side_in = {r_p_degen, r_p_hs, r_p_neg[2], r_p_neg[1], r_p_neg[0],
                        r_p_mag[2], r_p_mag[1], r_p_mag[0]};

    rmq_sqrt_pipe #(.W(W), .SIDE_W(SW1)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_p_vld),
        .i_rad   (r_p_rad),
        .i_side  (s_side_in),
        .o_valid (s_vld),
        .o_root  (s_root),
        .o_side  (s_side)
    );

    // division
    logic [W:0]     d_mag [3];
    logic [SW2-1:0] d_side_in;
    logic [SW2-1:0] d_side;
    logic           d_vld;
    logic [W-1:0]   d_quo [3];
    logic           d_ovf [3];

    assign d_mag[0]  = s_side[W:0];
    assign d_mag[1]  = s_side[2*W+1:W+1];
    assign d_mag[2]  = s_side[3*W+2:2*W+2];
    assign d_side_in = {s_side[SW1-1:3*(W+1)], s_root};

    rmq_div_pipe #(.W(W), .SIDE_W(SW2)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_vld),
        .i_root  (s_root),
        .i_mag   (d_mag),
        .i_side  (d_side_in),
        .o_valid (d_vld),
        .o_quo   (d_quo),
        .o_ovf   (d_ovf),
        .o_side  (d_side)
    );

    // round, saturate and steer into the component slots
    logic [W-1:0]        f_root;
    logic                f_neg [3];
    t_slot               f_hs;
    logic                f_degen;
    logic [W:0]          f_half;
    logic signed [W-1:0] lane_val [3];
    logic signed [W-1:0] n_q [4];
    t_slot               lane;

    assign f_root  = d_side[W-1:0];
    assign f_neg   = '{d_side[W], d_side[W+1], d_side[W+2]};
    assign f_hs    = d_side[W+4:W+3];
    assign f_degen = d_side[W+5];
    assign f_half  = ((W+1)'(f_root) + (W+1)'(1)) >> 1;

    always_comb begin
        lane = SLOT_W;
        for (int l = 0; l < 3; l++) begin
            if (f_neg[l]) begin
                lane_val[l] = (d_ovf[l] || (d_quo[l] > NLIM)) ? SMIN : -$signed(d_quo[l]);
            end else begin
                lane_val[l] = (d_ovf[l] || d_quo[l][W-1]) ? SMAX : $signed(d_quo[l]);
            end
        end
        for (int n = 0; n < 4; n++) begin
            lane = (2'(n) > f_hs) ? 2'(n - 1) : 2'(n);
            if (f_degen) begin
                n_q[n] = '0;
            end else if (2'(n) == f_hs) begin
                n_q[n] = $signed(f_half[W-1:0]);
            end else begin
                n_q[n] = lane_val[lane];
            end
        end
    end

    logic                r_out_vld;
    logic signed [W-1:0] r_q [4];
    logic                r_degen;

    assign en = !r_out_vld || o_quat.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_q     <= n_q;
            r_degen <= f_degen;
        end
    end

    assign i_mat.ready       = en;
    assign o_quat.valid      = r_out_vld;
    assign o_quat.qw         = r_q[SLOT_W];
    assign o_quat.qx         = r_q[SLOT_X];
    assign o_quat.qy         = r_q[SLOT_Y];
    assign o_quat.qz         = r_q[SLOT_Z];
    assign o_quat.degenerate = r_degen;

endmodule

// ----- sv/rmq_prep.sv -----
module rmq_prep #(
    parameter int W = 16
) (
    input  logic signed [W-1:0] i_m11,
    input  logic signed [W-1:0] i_m12,
    input  logic signed [W-1:0] i_m13,
    input  logic signed [W-1:0] i_m21,
    input  logic signed [W-1:0] i_m22,
    input  logic signed [W-1:0] i_m23,
    input  logic signed [W-1:0] i_m31,
    input  logic signed [W-1:0] i_m32,
    input  logic signed [W-1:0] i_m33,
    output logic [W:0]          o_rad,
    output logic                o_degen,
    output rmq_pkg::t_slot      o_hs,
    output logic                o_neg [3],
    output logic [W:0]          o_mag [3]
);
    import rmq_pkg::*;

    localparam int FRAC = W - 2;
    localparam logic signed [W+1:0] ONE = {2'b00, 2'b01, {FRAC{1'b0}}};

    logic signed [W+1:0] mm [4][4];
    logic signed [W+1:0] v  [4];
    logic signed [W+1:0] trace;
    logic signed [W+1:0] rad;
    logic signed [W+1:0] vv [3];
    logic signed [W+1:0] mw [3];
    t_slot               ai, aj, ak;
    t_slot               hs;
    t_slot               sl [3];

    function automatic logic signed [W+1:0] sx(input logic signed [W-1:0] a);
        return {{2{a[W-1]}}, a};
    endfunction

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                mm[r][c] = '0;
            end
        end
        mm[1][1] = sx(i_m11);
        mm[1][2] = sx(i_m12);
        mm[1][3] = sx(i_m13);
        mm[2][1] = sx(i_m21);
        mm[2][2] = sx(i_m22);
        mm[2][3] = sx(i_m23);
        mm[3][1] = sx(i_m31);
        mm[3][2] = sx(i_m32);
        mm[3][3] = sx(i_m33);

        for (int n = 0; n < 4; n++) begin
            v[n] = '0;
        end
        trace = mm[1][1] + mm[2][2] + mm[3][3];
        ai = SLOT_X;
        aj = SLOT_Y;
        ak = SLOT_Z;

        if (!trace[W+1] && (trace != '0)) begin
            hs        = SLOT_W;
            rad       = trace + ONE;
            v[SLOT_X] = mm[3][2] - mm[2][3];
            v[SLOT_Y] = mm[1][3] - mm[3][1];
            v[SLOT_Z] = mm[2][1] - mm[1][2];
        end else begin
            // largest diagonal picks the leading axis, ties keep the lower one
            if (mm[2][2] > mm[1][1]) begin
                ai = SLOT_Y;
            end
            if (mm[3][3] > mm[ai][ai]) begin
                ai = SLOT_Z;
            end
            aj        = axis_next(ai);
            ak        = axis_next(aj);
            hs        = ai;
            rad       = mm[ai][ai] - mm[aj][aj] - mm[ak][ak] + ONE;
            v[SLOT_W] = mm[ak][aj] - mm[aj][ak];
            v[aj]     = mm[aj][ai] + mm[ai][aj];
            v[ak]     = mm[ak][ai] + mm[ai][ak];
        end

        // three divider lanes take the slots other than the root slot, in order
        for (int t = 0; t < 3; t++) begin
            sl[t]    = (2'(t) >= hs) ? 2'(t + 1) : 2'(t);
            vv[t]    = v[sl[t]];
            o_neg[t] = vv[t][W+1];
            mw[t]    = vv[t][W+1] ? -vv[t] : vv[t];
            o_mag[t] = mw[t][W:0];
        end
    end

    assign o_rad   = rad[W:0];
    assign o_degen = rad[W+1] || (rad == '0);
    assign o_hs    = hs;

endmodule

// ----- sv/rmq_sqrt_pipe.sv -----
module rmq_sqrt_pipe #(
    parameter int W      = 16,
    parameter int SIDE_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [W:0]        i_rad,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [W-1:0]      o_root,
    output logic [SIDE_W-1:0] o_side
);
    localparam int FRAC = W - 2;
    localparam int RW   = 2 * W;

    logic [RW-1:0]     r_rem  [W];
    logic [W-1:0]      r_root [W];
    logic [SIDE_W-1:0] r_side [W];
    logic              r_vld  [W];

    // one root bit per stage, most significant first
    for (genvar g = 0; g < W; g++) begin : g_stage
        localparam int B = W - 1 - g;

        logic [RW-1:0]     rem_in;
        logic [W-1:0]      root_in;
        logic [SIDE_W-1:0] side_in;
        logic              vld_in;
        logic [RW:0]       trial;
        logic              take;
        logic [RW-1:0]     n_rem;
        logic [W-1:0]      n_root;

        if (g == 0) begin : g_first
            assign rem_in  = {1'b0, i_rad, {FRAC{1'b0}}};
            assign root_in = '0;
            assign side_in = i_side;
            assign vld_in  = i_valid;
        end else begin : g_next
            assign rem_in  = r_rem[g-1];
            assign root_in = r_root[g-1];
            assign side_in = r_side[g-1];
            assign vld_in  = r_vld[g-1];
        end

        assign trial  = ((RW+1)'(root_in) << (B + 1)) + ((RW+1)'(1) << (2 * B));
        assign take   = {1'b0, rem_in} >= trial;
        assign n_rem  = take ? (rem_in - trial[RW-1:0]) : rem_in;
        assign n_root = take ? (root_in | (W'(1) << B)) : root_in;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= n_rem;
                r_root[g] <= n_root;
                r_side[g] <= side_in;
            end
        end
    end

    assign o_valid = r_vld[W-1];
    assign o_root  = r_root[W-1];
    assign o_side  = r_side[W-1];

endmodule

// ----- sv/rmq_div_pipe.sv -----
module rmq_div_pipe #(
    parameter int W      = 16,
    parameter int SIDE_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [W-1:0]      i_root,
    input  logic [W:0]        i_mag [3],
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [W-1:0]      o_quo [3],
    output logic              o_ovf [3],
    output logic [SIDE_W-1:0] o_side
);
    localparam int FRAC = W - 2;
    localparam int NW   = 2 * W + 1;

    // setup stage: numerator with rounding term, divisor 2s, overflow test
    logic [NW-1:0]     r_n0   [3];
    logic              r_ovf0 [3];
    logic [W:0]        r_d0;
    logic [SIDE_W-1:0] r_side0;
    logic              r_vld0;

    logic [NW-1:0]     n_n0   [3];
    logic              n_ovf0 [3];
    logic [W:0]        n_d0;

    assign n_d0 = {i_root, 1'b0};

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            n_n0[l]   = (NW'(i_mag[l]) << FRAC) + NW'(i_root);
            n_ovf0[l] = n_n0[l] >= (NW'(n_d0) << W);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
        end else if (i_en) begin
            r_vld0 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n0    <= n_n0;
            r_ovf0  <= n_ovf0;
            r_d0    <= n_d0;
            r_side0 <= i_side;
        end
    end

    logic [NW-1:0]     r_rem  [W][3];
    logic [W-1:0]      r_q    [W][3];
    logic              r_ovf  [W][3];
    logic [W:0]        r_d    [W];
    logic [SIDE_W-1:0] r_side [W];
    logic              r_vld  [W];

    // one quotient bit per stage, most significant first
    for (genvar g = 0; g < W; g++) begin : g_stage
        localparam int B = W - 1 - g;

        logic [NW-1:0]     rem_in [3];
        logic [W-1:0]      q_in   [3];
        logic              ovf_in [3];
        logic [W:0]        d_in;
        logic [SIDE_W-1:0] side_in;
        logic              vld_in;
        logic [NW-1:0]     dsh;
        logic [NW-1:0]     n_rem  [3];
        logic [W-1:0]      n_q    [3];

        if (g == 0) begin : g_first
            assign d_in    = r_d0;
            assign side_in = r_side0;
            assign vld_in  = r_vld0;
            always_comb begin
                for (int l = 0; l < 3; l++) begin
                    rem_in[l] = r_n0[l];
                    q_in[l]   = '0;
                    ovf_in[l] = r_ovf0[l];
                end
            end
        end else begin : g_next
            assign d_in    = r_d[g-1];
            assign side_in = r_side[g-1];
            assign vld_in  = r_vld[g-1];
            always_comb begin
                for (int l = 0; l < 3; l++) begin
                    rem_in[l] = r_rem[g-1][l];
                    q_in[l]   = r_q[g-1][l];
                    ovf_in[l] = r_ovf[g-1][l];
                end
            end
        end

        assign dsh = NW'(d_in) << B;

        always_comb begin
            for (int l = 0; l < 3; l++) begin
                if (rem_in[l] >= dsh) begin
                    n_rem[l] = rem_in[l] - dsh;
                    n_q[l]   = q_in[l] | (W'(1) << B);
                end else begin
                    n_rem[l] = rem_in[l];
                    n_q[l]   = q_in[l];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= n_rem;
                r_q[g]    <= n_q;
                r_ovf[g]  <= ovf_in;
                r_d[g]    <= d_in;
                r_side[g] <= side_in;
            end
        end
    end

    assign o_valid = r_vld[W-1];
    assign o_quo   = r_q[W-1];
    assign o_ovf   = r_ovf[W-1];
    assign o_side  = r_side[W-1];

endmodule

// ----- sv/rmq_checker.sv -----
`include "rotation_matrix_to_quaternion_top_defines.svh"

module rmq_checker #(
    parameter int DATA_WIDTH = 16
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_ready,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic [DATA_WIDTH-1:0] i_qw,
    input logic [DATA_WIDTH-1:0] i_qx,
    input logic [DATA_WIDTH-1:0] i_qy,
    input logic [DATA_WIDTH-1:0] i_qz,
    input logic                  i_degenerate
);

    // a degenerate transaction carries an all-zero quaternion
    `RMQ_ASSERT_NOW(a_degen_zero, i_out_valid && i_degenerate, (i_qw == '0) && (i_qx == '0) && (i_qy == '0) && (i_qz == '0))

    // input side advances exactly when the output register can move
    `RMQ_ASSERT_NOW(a_ready_follows_out, 1'b1, i_in_ready == (!i_out_valid || i_out_ready))

    // a stalled result holds
    `RMQ_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_qw) && $stable(i_qx) && $stable(i_qy) && $stable(i_qz) && $stable(i_degenerate))

    // reset empties the pipeline
    `RMQ_ASSERT_RST(a_reset_empty, !i_rst_n, !i_out_valid)

endmodule

bind rotation_matrix_to_quaternion_top rmq_checker #(.DATA_WIDTH(DATA_WIDTH)) u_rmq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_mat.ready),
    .i_out_valid  (o_quat.valid),
    .i_out_ready  (o_quat.ready),
    .i_qw         (o_quat.qw),
    .i_qx         (o_quat.qx),
    .i_qy         (o_quat.qy),
    .i_qz         (o_quat.qz),
    .i_degenerate (o_quat.degenerate)
);

// ----- tb/rmq_tb_if.sv -----
`timescale 1ns / 1ps

// Channels for the matrix input and quaternion output live in the RTL files.
// This file is kept for the testbench's own scoreboard types.
package rmq_tb_pkg;

    typedef struct packed {
        logic signed [15:0] qw;
        logic signed [15:0] qx;
        logic signed [15:0] qy;
        logic signed [15:0] qz;
        logic               degenerate;
    } t_quat;

    typedef logic signed [15:0] t_mat [1:3][1:3];

endpackage

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import rmq_pkg::*;
    import rmq_tb_pkg::*;

    localparam int W = 16;
    localparam int FRAC = W - 2;
    localparam longint SMAX = (64'sd1 <<< (W - 1)) - 1;
    localparam longint SMIN = -SMAX - 1;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    rmq_mat_if  #(.W(W)) mat_ch ();
    rmq_quat_if #(.W(W)) quat_ch ();

    rotation_matrix_to_quaternion_top #(.DATA_WIDTH(W)) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_mat  (mat_ch.sink),
        .o_quat (quat_ch.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // Round-to-nearest of v * 0.5 / s, ties away from zero.
    function automatic longint scale_half(input longint v, input longint unsigned s);
        longint unsigned a, qq;
        a = (v < 0) ? longint'(-v) : v;
        qq = ((a << FRAC) + s) / (2 * s);
        return (v < 0) ? -longint'(qq) : longint'(qq);
    endfunction

    function automatic logic signed [W-1:0] clamp(input longint v);
        if (v > SMAX) return SMAX[W-1:0];
        if (v < SMIN) return SMIN[W-1:0];
        return v[W-1:0];
    endfunction

    function automatic t_quat matrix_to_quat(input t_mat mm);
        longint m [1:3][1:3];
        longint q [0:3];
        longint one, tr, rad;
        longint unsigned s;
        int i, j, k;
        t_quat r;
        one = 64'sd1 <<< FRAC;
        for (int a = 1; a <= 3; a++)
            for (int b = 1; b <= 3; b++) m[a][b] = mm[a][b];
        for (int n = 0; n < 4; n++) q[n] = 0;
        r.degenerate = 1'b0;
        tr = m[1][1] + m[2][2] + m[3][3];
        if (tr > 0) begin
            s = int_sqrt(longint'(tr + one) << FRAC);
            q[0] = (s + 1) >> 1;
            q[1] = scale_half(m[3][2] - m[2][3], s);
            q[2] = scale_half(m[1][3] - m[3][1], s);
            q[3] = scale_half(m[2][1] - m[1][2], s);
        end else begin
            i = 1;
            if (m[2][2] > m[1][1]) i = 2;
            if (m[3][3] > m[i][i]) i = 3;
            j = int'(axis_next(t_slot'(i)));
            k = int'(axis_next(t_slot'(j)));
            rad = m[i][i] - m[j][j] - m[k][k] + one;
            if (rad <= 0) begin
                r.degenerate = 1'b1;
            end else begin
                s = int_sqrt(longint'(rad) << FRAC);
                q[i] = (s + 1) >> 1;
                q[0] = scale_half(m[k][j] - m[j][k], s);
                q[j] = scale_half(m[j][i] + m[i][j], s);
                q[k] = scale_half(m[k][i] + m[i][k], s);
            end
        end
        r.qw = clamp(q[0]);
        r.qx = clamp(q[1]);
        r.qy = clamp(q[2]);
        r.qz = clamp(q[3]);
        return r;
    endfunction

    class quat_scoreboard;
        t_quat pending[$];
        int    mismatches;

        function void note_matrix(t_mat mm);
            pending.push_back(matrix_to_quat(mm));
        endfunction

        function void check_quat(t_quat got);
            t_quat exp_q;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected quaternion %p", got);
                return;
            end
            exp_q = pending.pop_front();
            if (got !== exp_q) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: expected w=%0d x=%0d y=%0d z=%0d d=%0b, ",
                              "got w=%0d x=%0d y=%0d z=%0d d=%0b"},
                             exp_q.qw, exp_q.qx, exp_q.qy, exp_q.qz, exp_q.degenerate,
                             got.qw, got.qx, got.qy, got.qz, got.degenerate);
            end
        endfunction
    endclass

    quat_scoreboard sb = new();
    int send_idle_pct;
    int recv_idle_pct;

    initial begin
        mat_ch.valid = 1'b0;
        {mat_ch.m11, mat_ch.m12, mat_ch.m13, mat_ch.m21, mat_ch.m22, mat_ch.m23,
         mat_ch.m31, mat_ch.m32, mat_ch.m33} = '0;
        quat_ch.ready = 1'b0;
    end

    // Receiver: random stall, check every accepted transaction.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (quat_ch.valid && quat_ch.ready)
                sb.check_quat('{quat_ch.qw, quat_ch.qx, quat_ch.qy, quat_ch.qz,
                               quat_ch.degenerate});
            quat_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Hold valid across back-to-back transactions; drop it only while idling.
    task automatic send_matrix(input t_mat mm);
        while ($urandom_range(99) < send_idle_pct) begin
            mat_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        mat_ch.valid <= 1'b1;
        mat_ch.m11 <= mm[1][1]; mat_ch.m12 <= mm[1][2]; mat_ch.m13 <= mm[1][3];
        mat_ch.m21 <= mm[2][1]; mat_ch.m22 <= mm[2][2]; mat_ch.m23 <= mm[2][3];
        mat_ch.m31 <= mm[3][1]; mat_ch.m32 <= mm[3][2]; mat_ch.m33 <= mm[3][3];
        do @(posedge i_clk); while (!mat_ch.ready);
        sb.note_matrix(mm);
    endtask

    task automatic fill_matrix(output t_mat mm, input int lim);
        for (int a = 1; a <= 3; a++)
            for (int b = 1; b <= 3; b++)
                mm[a][b] = $urandom_range(2 * lim) - lim;
    endtask

    // Build a near-rotation: a dominant diagonal entry picks the branch.
    task automatic rotation_like(output t_mat mm);
        int kind;
        fill_matrix(mm, 8000);
        kind = $urandom_range(3);
        if (kind == 0) begin
            for (int a = 1; a <= 3; a++) mm[a][a] = $urandom_range(16384, 4000);
        end else begin
            mm[kind][kind] = $urandom_range(16384, 8000);
            for (int a = 1; a <= 3; a++)
                if (a != kind) mm[a][a] = -$signed(16'($urandom_range(16384, 6000)));
        end
    endtask

    task automatic send_batch(input int n);
        t_mat mm;
        int pick;
        for (int t = 0; t < n; t++) begin
            pick = $urandom_range(9);
            if (pick < 6) rotation_like(mm);
            else if (pick < 9) fill_matrix(mm, 32768);
            else begin
                fill_matrix(mm, 32768);
                for (int a = 1; a <= 3; a++)
                    for (int b = 1; b <= 3; b++)
                        if ($urandom_range(1))
                            mm[a][b] = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            end
            send_matrix(mm);
        end
    endtask

    task automatic directed;
        t_mat mm;
        // identity, then for each axis that axis kept and the other two negated
        for (int v = 0; v < 4; v++) begin
            for (int a = 1; a <= 3; a++)
                for (int b = 1; b <= 3; b++)
                    mm[a][b] = (a != b) ? 16'sd0 :
                               ((v == 0 || v == a) ? 16'sd16384 : -16'sd16384);
            send_matrix(mm);
        end
        // all minimum, all maximum, zero matrix
        foreach (mm[a, b]) mm[a][b] = 16'sh8000;
        send_matrix(mm);
        foreach (mm[a, b]) mm[a][b] = 16'sh7fff;
        send_matrix(mm);
        foreach (mm[a, b]) mm[a][b] = 16'sd0;
        send_matrix(mm);
        // diagonal all minus one
        foreach (mm[a, b]) mm[a][b] = (a == b) ? -16'sd16384 : 16'sd0;
        send_matrix(mm);
        // diagonal ties, lower index kept
        foreach (mm[a, b]) mm[a][b] = (a == b) ? -16'sd4000 : 16'sd1000;
        send_matrix(mm);
        // trace exactly zero
        foreach (mm[a, b]) mm[a][b] = 16'sd0;
        mm[1][1] = 16'sd100; mm[2][2] = -16'sd100;
        send_matrix(mm);
        // large off-diagonal entries
        foreach (mm[a, b]) mm[a][b] = (a == b) ? -16'sd16000 : 16'sh7fff;
        mm[1][1] = -16'sd15000; mm[2][3] = 16'sh8000; mm[1][2] = 16'sh8000;
        send_matrix(mm);
        foreach (mm[a, b]) mm[a][b] = (a == b) ? 16'sd1 : 16'sh8000;
        send_matrix(mm);
    endtask

    initial begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_pct = 11; recv_idle_pct = 85;
        directed();
        send_batch(530);
        send_idle_pct = 85; recv_idle_pct = 11;
        send_batch(530);
        send_idle_pct = 0; recv_idle_pct = 0;
        send_batch(570);
        mat_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    initial begin
        #10ms;
        $display("tb failed");
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+sv
sv/rmq_pkg.sv
sv/rmq_mat_if.sv
sv/rmq_quat_if.sv
sv/rmq_prep.sv
sv/rmq_sqrt_pipe.sv
sv/rmq_div_pipe.sv
sv/rotation_matrix_to_quaternion_top.sv
sv/rmq_checker.sv
tb/rmq_tb_if.sv
tb/tb.sv
